[sv/sbdfr_pkg.sv]
// ----------------------------------------------------------------------------
// Serial bus frame responder package
// Shared types, register indexes, frame kinds and the response ROM.
// ----------------------------------------------------------------------------
package sbdfr_pkg;

	localparam int MAX_FRAMES = 64;

	localparam logic [31:0] END_BIT     = 32'h8000_0000;
	localparam logic [15:0] AXIS_BIAS   = 16'd512;
	localparam logic [7:0]  BASE_UNIT   = 8'h20;
	localparam logic [7:0]  NO_RESPONSE = 8'hff;
	localparam logic [7:0]  INFO_WORDS  = 8'd28;
	localparam logic [7:0]  CMD_INFO    = 8'd1;
	localparam logic [7:0]  CMD_COND    = 8'd9;

	localparam logic [1:0] PORT_KBD = 2'd0;
	localparam logic [1:0] PORT_PTR = 2'd1;
	localparam logic [1:0] PORT_CTL = 2'd2;

	localparam logic REG_LIST_BASE = 1'b0;
	localparam logic REG_STORAGE   = 1'b1;

	typedef enum logic [2:0] {
		KIND_INFO_KBD,
		KIND_INFO_PTR,
		KIND_INFO_CTL,
		KIND_KBD,
		KIND_PTR,
		KIND_CTL,
		KIND_NORESP,
		KIND_FWD
	} kind_t;

	typedef struct packed {
		logic [31:0]        frame_header;
		logic [31:0]        receive_address;
		logic [31:0]        command_word;
		logic [63:0]        key_report;
		logic [2:0]         pointer_buttons;
		logic signed [7:0]  pointer_dx;
		logic signed [7:0]  pointer_dy;
		logic signed [7:0]  pointer_dz;
	} in_word_t;

	typedef struct packed {
		logic [31:0] write_address;
		logic [31:0] write_word;
		logic        frame_last;
		logic        walk_ended;
		logic [31:0] next_frame_address;
		logic        forward_to_storage;
	} out_word_t;

	typedef struct packed {
		kind_t              kind;
		logic [31:0]        recv;
		logic               ended;
		logic [31:0]        next;
		logic [63:0]        key_report;
		logic [2:0]         buttons;
		logic signed [7:0]  dx;
		logic signed [7:0]  dy;
		logic signed [7:0]  dz;
	} frame_t;

	localparam logic [7:0] KBD_LABEL [30] = '{
		8'h4B, 8'h65, 8'h79, 8'h62, 8'h6F, 8'h61, 8'h72, 8'h64, 8'h20, 8'h20,
		8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20,
		8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20
	};

	localparam logic [7:0] PTR_LABEL [30] = '{
		8'h4D, 8'h6F, 8'h75, 8'h73, 8'h65, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20,
		8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20,
		8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20
	};

	localparam logic [7:0] CTL_LABEL [30] = '{
		8'h44, 8'h72, 8'h65, 8'h61, 8'h6D, 8'h63, 8'h61, 8'h73, 8'h74, 8'h20,
		8'h43, 8'h6F, 8'h6E, 8'h74, 8'h72, 8'h6F, 8'h6C, 8'h6C, 8'h65, 8'h72,
		8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20
	};

	localparam logic [7:0] NOTICE_TEXT [60] = '{
		8'h50, 8'h72, 8'h6F, 8'h64, 8'h75, 8'h63, 8'h65, 8'h64, 8'h20, 8'h42,
		8'h79, 8'h20, 8'h6F, 8'h72, 8'h20, 8'h55, 8'h6E, 8'h64, 8'h65, 8'h72,
		8'h20, 8'h4C, 8'h69, 8'h63, 8'h65, 8'h6E, 8'h73, 8'h65, 8'h20, 8'h46,
		8'h72, 8'h6F, 8'h6D, 8'h20, 8'h53, 8'h45, 8'h47, 8'h41, 8'h20, 8'h45,
		8'h4E, 8'h54, 8'h45, 8'h52, 8'h50, 8'h52, 8'h49, 8'h53, 8'h45, 8'h53,
		8'h2C, 8'h4C, 8'h54, 8'h44, 8'h2E, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20
	};

	// Index of the final response word for each kind of frame.
	function automatic logic [4:0] last_index(kind_t kind);
		logic [4:0] r;
		case (kind)
			KIND_INFO_KBD, KIND_INFO_PTR, KIND_INFO_CTL: r = 5'd28;
			KIND_KBD: r = 5'd3;
			KIND_PTR: r = 5'd4;
			KIND_CTL: r = 5'd3;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] info_byte(kind_t kind, logic [6:0] idx);
		logic [7:0]  sender;
		logic [7:0]  recip;
		logic [31:0] func;
		logic [4:0]  loff;
		logic [5:0]  noff;
		logic [7:0]  lbyte;
		logic [7:0]  r;
		case (kind)
			KIND_INFO_PTR: begin
				sender = 8'h60;
				recip = 8'h00;
				func = 32'h0000_0200;
			end
			KIND_INFO_CTL: begin
				sender = 8'h80;
				recip = 8'h21;
				func = 32'h0000_0001;
			end
			default: begin
				sender = 8'h20;
				recip = 8'h00;
				func = 32'h0000_0040;
			end
		endcase
		loff = 5'(idx - 7'd22);
		noff = 6'(idx - 7'd52);
		case (kind)
			KIND_INFO_PTR: lbyte = PTR_LABEL[loff];
			KIND_INFO_CTL: lbyte = CTL_LABEL[loff];
			default: lbyte = KBD_LABEL[loff];
		endcase
		if (idx == 7'd0) begin
			r = 8'd5;
		end else if (idx == 7'd1) begin
			r = sender;
		end else if (idx == 7'd2) begin
			r = recip;
		end else if (idx == 7'd3) begin
			r = INFO_WORDS;
		end else if (idx == 7'd4) begin
			r = func[31:24];
		end else if (idx == 7'd5) begin
			r = func[23:16];
		end else if (idx == 7'd6) begin
			r = func[15:8];
		end else if (idx == 7'd7) begin
			r = func[7:0];
		end else if (idx == 7'd20) begin
			r = 8'hff;
		end else if (idx >= 7'd22 && idx < 7'd52) begin
			r = lbyte;
		end else if (idx >= 7'd52 && idx < 7'd112) begin
			r = NOTICE_TEXT[noff];
		end else begin
			r = 8'h00;
		end
		return r;
	endfunction

	function automatic logic [31:0] info_word(kind_t kind, logic [4:0] k);
		logic [6:0] base;
		base = {k, 2'b00};
		return {info_byte(kind, base + 7'd3), info_byte(kind, base + 7'd2),
			info_byte(kind, base + 7'd1), info_byte(kind, base)};
	endfunction

endpackage

[sv/sbdfr_word_gen.sv]
// ----------------------------------------------------------------------------
// Response word generator
// Builds response word k of a decoded frame from the ROM and the reports.
// ----------------------------------------------------------------------------
module sbdfr_word_gen (
	input  sbdfr_pkg::frame_t frame,
	input  logic [4:0]        idx,
	output logic [31:0]       word
);

	logic [7:0]  btn;
	logic [15:0] ax;
	logic [15:0] ay;
	logic [15:0] az;

	assign btn = {4'b0000, frame.buttons[2], frame.buttons[0], frame.buttons[1], 1'b0};
	assign ax  = {{8{frame.dx[7]}}, frame.dx} + sbdfr_pkg::AXIS_BIAS;
	assign ay  = {{8{frame.dy[7]}}, frame.dy} + sbdfr_pkg::AXIS_BIAS;
	assign az  = {{8{frame.dz[7]}}, frame.dz} + sbdfr_pkg::AXIS_BIAS;

	always_comb begin
		word = 32'h0;
		case (frame.kind)
			sbdfr_pkg::KIND_INFO_KBD, sbdfr_pkg::KIND_INFO_PTR,
			sbdfr_pkg::KIND_INFO_CTL: begin
				word = sbdfr_pkg::info_word(frame.kind, idx);
			end
			sbdfr_pkg::KIND_KBD: begin
				case (idx)
					5'd0: word = 32'h0300_2008;
					5'd1: word = 32'h4000_0000;
					5'd2: word = frame.key_report[31:0];
					5'd3: word = frame.key_report[63:32];
					default: word = 32'h0;
				endcase
			end
			sbdfr_pkg::KIND_PTR: begin
				case (idx)
					5'd0: word = 32'h0400_6008;
					5'd1: word = 32'h0002_0000;
					5'd2: word = {16'h0000, 8'hff, ~btn};
					5'd3: word = {ay, ax};
					5'd4: word = {16'h0000, az};
					default: word = 32'h0;
				endcase
			end
			sbdfr_pkg::KIND_CTL: begin
				case (idx)
					5'd0: word = 32'h03A0_8008;
					5'd1: word = 32'h0100_0000;
					5'd2: word = 32'h0000_FFFF;
					5'd3: word = 32'h8080_8080;
					default: word = 32'h0;
				endcase
			end
			sbdfr_pkg::KIND_NORESP: word = {24'h0, sbdfr_pkg::NO_RESPONSE};
			default: word = 32'h0;
		endcase
	end

endmodule

[sv/serial_bus_dma_frame_responder.sv]
// ----------------------------------------------------------------------------
// Serial bus DMA frame responder
// Decodes command frames and streams the response frame as memory words.
// ----------------------------------------------------------------------------
// A frame is decoded into a frame register as it is accepted, and its response
// words then leave one per cycle through the result register unless the output
// side stalls. A frame has as many response words as its kind needs: 1 for a
// no-response or storage notice, 4 for keyboard or controller condition, 5 for
// pointer condition and 29 for device information. The next frame is accepted
// in the cycle the last word of the current one moves into the result register,
// so frames follow without a gap while the output side keeps taking words.
module serial_bus_dma_frame_responder (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic                  cfg_index,
	input  logic [31:0]           cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  sbdfr_pkg::in_word_t   in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output sbdfr_pkg::out_word_t  out_data
);

	logic [31:0]          base_q;
	logic                 storage_q;
	logic [31:0]          frame_ptr_q;
	logic [6:0]           frames_done_q;

	logic                 valid_s1;
	sbdfr_pkg::frame_t    frame_s1;
	logic [4:0]           idx_s1;

	logic                 out_valid_q;
	sbdfr_pkg::out_word_t out_q;

	sbdfr_pkg::frame_t    dec;
	logic [1:0]           port;
	logic [7:0]           cmd;
	logic [7:0]           recip;
	logic [9:0]           span;
	logic                 in_acc;
	logic                 out_free;
	logic                 emit;
	logic                 last;
	logic [31:0]          word;

	assign port  = in_data.frame_header[17:16];
	assign cmd   = in_data.command_word[7:0];
	assign recip = in_data.command_word[15:8];
	assign span  = 10'(in_data.frame_header[7:0]) + 10'd3;

	always_comb begin
		dec.recv       = in_data.receive_address;
		dec.next       = frame_ptr_q + {20'h0, span, 2'b00};
		dec.ended      = ((in_data.frame_header & sbdfr_pkg::END_BIT) != 32'h0)
			|| (({1'b0, frames_done_q} + 8'd1) >= 8'(sbdfr_pkg::MAX_FRAMES));
		dec.key_report = in_data.key_report;
		dec.buttons    = in_data.pointer_buttons;
		dec.dx         = in_data.pointer_dx;
		dec.dy         = in_data.pointer_dy;
		dec.dz         = in_data.pointer_dz;
		dec.kind       = sbdfr_pkg::KIND_NORESP;
		if ((recip & sbdfr_pkg::BASE_UNIT) != 8'h0) begin
			if (port == sbdfr_pkg::PORT_KBD && cmd == sbdfr_pkg::CMD_INFO) begin
				dec.kind = sbdfr_pkg::KIND_INFO_KBD;
			end else if (port == sbdfr_pkg::PORT_KBD && cmd == sbdfr_pkg::CMD_COND) begin
				dec.kind = sbdfr_pkg::KIND_KBD;
			end else if (port == sbdfr_pkg::PORT_PTR && cmd == sbdfr_pkg::CMD_INFO) begin
				dec.kind = sbdfr_pkg::KIND_INFO_PTR;
			end else if (port == sbdfr_pkg::PORT_PTR && cmd == sbdfr_pkg::CMD_COND) begin
				dec.kind = sbdfr_pkg::KIND_PTR;
			end else if (port == sbdfr_pkg::PORT_CTL && storage_q
				&& cmd == sbdfr_pkg::CMD_INFO) begin
				dec.kind = sbdfr_pkg::KIND_INFO_CTL;
			end else if (port == sbdfr_pkg::PORT_CTL && storage_q
				&& cmd == sbdfr_pkg::CMD_COND) begin
				dec.kind = sbdfr_pkg::KIND_CTL;
			end
		end else if (port == sbdfr_pkg::PORT_CTL && recip[0] && storage_q) begin
			dec.kind = sbdfr_pkg::KIND_FWD;
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign emit     = valid_s1 && out_free;
	assign last     = idx_s1 == sbdfr_pkg::last_index(frame_s1.kind);
	assign in_stall = valid_s1 && !(emit && last);
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q        <= 32'h0;
			storage_q     <= 1'b0;
			frame_ptr_q   <= 32'h0;
			frames_done_q <= 7'h0;
		end else if (cfg_wr_en) begin
			if (cfg_index == sbdfr_pkg::REG_LIST_BASE) begin
				base_q        <= cfg_wdata;
				frame_ptr_q   <= cfg_wdata;
				frames_done_q <= 7'h0;
			end else begin
				storage_q <= cfg_wdata[0];
			end
		end else if (in_acc) begin
			if (dec.ended) begin
				frame_ptr_q   <= base_q;
				frames_done_q <= 7'h0;
			end else begin
				frame_ptr_q   <= dec.next;
				frames_done_q <= frames_done_q + 7'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			idx_s1      <= 5'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
				idx_s1   <= 5'd0;
			end else if (emit && last) begin
				valid_s1 <= 1'b0;
			end else if (emit) begin
				idx_s1 <= idx_s1 + 5'd1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	sbdfr_word_gen u_word_gen (
		.frame (frame_s1),
		.idx   (idx_s1),
		.word  (word)
	);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			frame_s1 <= dec;
		end
		if (emit) begin
			out_q.write_address      <= frame_s1.recv + {25'h0, idx_s1, 2'b00};
			out_q.write_word         <= word;
			out_q.frame_last         <= last;
			out_q.walk_ended         <= frame_s1.ended;
			out_q.next_frame_address <= frame_s1.next;
			out_q.forward_to_storage <= frame_s1.kind == sbdfr_pkg::KIND_FWD;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

[sv/sbdfr_checker.sv]
// ----------------------------------------------------------------------------
// Frame responder checker
// Port-level properties of the response stream, bound to the top level.
// ----------------------------------------------------------------------------
module sbdfr_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_stall,
	input sbdfr_pkg::out_word_t out_data
);

	// A stalled word stays on the port unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("response word changed while stalled");

	// A storage notice is a single zero word.
	a_fwd_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.forward_to_storage
		|-> out_data.frame_last && out_data.write_word == 32'h0)
		else $error("storage notice is not a single zero word");

	// Words of one frame follow at consecutive addresses with no gap.
	a_frame_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !out_data.frame_last
		|=> out_valid
			&& out_data.write_address == $past(out_data.write_address) + 32'd4
			&& out_data.next_frame_address == $past(out_data.next_frame_address)
			&& out_data.walk_ended == $past(out_data.walk_ended))
		else $error("response frame words are not contiguous");

endmodule

bind serial_bus_dma_frame_responder sbdfr_checker u_sbdfr_checker (.*);

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// Serial bus DMA frame responder testbench
// Feeds command frames through the responder under random idling on both
// sides and checks every response word against a frame predictor kept in
// step with the list walk and the register settings.
// ----------------------------------------------------------------------------
module tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 400;

	localparam logic [63:0]  KBD_NAME = "Keyboard";
	localparam logic [39:0]  PTR_NAME = "Mouse";
	localparam logic [159:0] CTL_NAME =
		160'h4472_6561_6D63_6173_7420_436F_6E74_726F_6C6C_6572;
	localparam logic [479:0] LEGAL_TEXT = {
		80'h50726F64756365642042, 80'h79206F7220556E646572,
		80'h204C6963656E73652046, 80'h726F6D20534547412045,
		80'h4E544552505249534553, 80'h2C4C54442E2020202020
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic                 cfg_index = 1'b0;
	logic [31:0]          cfg_wdata = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	sbdfr_pkg::in_word_t  in_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	sbdfr_pkg::out_word_t out_data;

	sbdfr_pkg::in_word_t  frame_q [$];
	sbdfr_pkg::out_word_t pending_words [$];

	logic [31:0] base_reg = '0;
	logic        storage_on = 1'b0;
	logic [31:0] walk_ptr = '0;
	int          walk_count = 0;

	logic        calm = 1'b0;
	logic        squeeze_req = 1'b0;
	logic        squeezed = 1'b0;
	int          hold_left = 0;

	int errors = 0;
	int frames_taken = 0;
	int words_seen = 0;
	int reg_writes = 0;
	int n_info = 0;
	int n_cond = 0;
	int n_none = 0;
	int n_fwd = 0;
	int end_bit_stops = 0;
	int limit_stops = 0;
	int cycle_count = 0;

	serial_bus_dma_frame_responder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always #4 clk = ~clk;

	// Builds the response bytes of one frame, queues its words and advances
	// the list walk.
	function automatic void respond(input sbdfr_pkg::in_word_t f);
		logic [7:0]  b [116];
		logic [1:0]  port;
		logic [7:0]  cmd;
		logic [7:0]  to;
		logic [7:0]  btn;
		logic [15:0] ax [3];
		logic [31:0] nxt;
		logic [31:0] func;
		logic        ended;
		logic        known;
		logic        fwd;
		int          n;
		sbdfr_pkg::out_word_t o;
		port = f.frame_header[17:16];
		cmd = f.command_word[7:0];
		to = f.command_word[15:8];
		nxt = walk_ptr + (32'd3 + 32'(f.frame_header[7:0])) * 32'd4;
		ended = f.frame_header[31] || (walk_count + 1 >= sbdfr_pkg::MAX_FRAMES);
		known = port == sbdfr_pkg::PORT_KBD || port == sbdfr_pkg::PORT_PTR
			|| (port == sbdfr_pkg::PORT_CTL && storage_on);
		fwd = !to[5] && port == sbdfr_pkg::PORT_CTL && to[0] && storage_on;
		for (int i = 0; i < 116; i++) b[i] = 8'h00;
		n = 4;
		if (to[5] && known && cmd == sbdfr_pkg::CMD_INFO) begin
			n = 116;
			n_info++;
			case (port)
				sbdfr_pkg::PORT_KBD: begin
					b[1] = 8'h20;
					func = 32'h0000_0040;
				end
				sbdfr_pkg::PORT_PTR: begin
					b[1] = 8'h60;
					func = 32'h0000_0200;
				end
				default: begin
					b[1] = 8'h80;
					b[2] = 8'h21;
					func = 32'h0000_0001;
				end
			endcase
			b[0] = 8'd5;
			b[3] = 8'd28;
			b[4] = func[31:24];
			b[5] = func[23:16];
			b[6] = func[15:8];
			b[7] = func[7:0];
			b[20] = 8'hff;
			for (int i = 0; i < 30; i++) begin
				case (port)
					sbdfr_pkg::PORT_KBD:
						b[22 + i] = (i < 8) ? KBD_NAME[8 * (7 - i) +: 8] : 8'h20;
					sbdfr_pkg::PORT_PTR:
						b[22 + i] = (i < 5) ? PTR_NAME[8 * (4 - i) +: 8] : 8'h20;
					default:
						b[22 + i] = (i < 20) ? CTL_NAME[8 * (19 - i) +: 8] : 8'h20;
				endcase
			end
			for (int i = 0; i < 60; i++) b[52 + i] = LEGAL_TEXT[8 * (59 - i) +: 8];
		end else if (to[5] && known && cmd == sbdfr_pkg::CMD_COND) begin
			n_cond++;
			b[0] = 8'd8;
			b[3] = 8'd3;
			if (port == sbdfr_pkg::PORT_KBD) begin
				n = 16;
				b[1] = 8'h20;
				b[7] = 8'h40;
				for (int i = 0; i < 8; i++) b[8 + i] = f.key_report[8 * i +: 8];
			end else if (port == sbdfr_pkg::PORT_PTR) begin
				n = 20;
				b[1] = 8'h60;
				b[3] = 8'd4;
				b[6] = 8'h02;
				btn = {4'b0, f.pointer_buttons[2], f.pointer_buttons[0],
					f.pointer_buttons[1], 1'b0};
				b[8] = ~btn;
				b[9] = 8'hff;
				ax[0] = 16'd512 + {{8{f.pointer_dx[7]}}, f.pointer_dx};
				ax[1] = 16'd512 + {{8{f.pointer_dy[7]}}, f.pointer_dy};
				ax[2] = 16'd512 + {{8{f.pointer_dz[7]}}, f.pointer_dz};
				for (int i = 0; i < 3; i++) begin
					b[12 + 2 * i] = ax[i][7:0];
					b[13 + 2 * i] = ax[i][15:8];
				end
			end else begin
				n = 16;
				b[1] = 8'h80;
				b[2] = 8'hA0;
				b[7] = 8'h01;
				b[8] = 8'hff;
				b[9] = 8'hff;
				for (int i = 12; i < 16; i++) b[i] = 8'h80;
			end
		end else if (fwd) begin
			n_fwd++;
		end else begin
			n_none++;
			b[0] = sbdfr_pkg::NO_RESPONSE;
		end
		for (int k = 0; k < n / 4; k++) begin
			o.write_address = f.receive_address + 32'(4 * k);
			o.write_word = {b[4 * k + 3], b[4 * k + 2], b[4 * k + 1], b[4 * k]};
			o.frame_last = (k == n / 4 - 1);
			o.walk_ended = ended;
			o.next_frame_address = nxt;
			o.forward_to_storage = fwd;
			pending_words.push_back(o);
		end
		if (ended) begin
			if (f.frame_header[31])
				end_bit_stops++;
			else
				limit_stops++;
			walk_ptr = base_reg;
			walk_count = 0;
		end else begin
			walk_ptr = nxt;
			walk_count = (walk_count + 1) & 127;
		end
	endfunction

	function automatic sbdfr_pkg::in_word_t mk_frame(input logic [1:0] port,
			input logic [7:0] to, input logic [7:0] cmd, input logic end_bit);
		sbdfr_pkg::in_word_t f;
		f.frame_header = $urandom;
		f.frame_header[31] = end_bit;
		f.frame_header[17:16] = port;
		f.receive_address = $urandom;
		f.command_word = $urandom;
		f.command_word[15:8] = to;
		f.command_word[7:0] = cmd;
		f.key_report = {$urandom, $urandom};
		f.pointer_buttons = 3'($urandom);
		f.pointer_dx = 8'($urandom);
		f.pointer_dy = 8'($urandom);
		f.pointer_dz = 8'($urandom);
		return f;
	endfunction

	function automatic sbdfr_pkg::in_word_t rand_frame(input bit ends_ok);
		logic [7:0] cmd;
		logic [7:0] to;
		int         pick;
		pick = $urandom_range(9);
		cmd = (pick < 4) ? sbdfr_pkg::CMD_INFO : (pick < 8) ? sbdfr_pkg::CMD_COND
			: 8'($urandom);
		to = 8'($urandom);
		to[5] = ($urandom_range(9) < 7);
		return mk_frame(2'($urandom), to, cmd, ends_ok && $urandom_range(7) == 0);
	endfunction

	task automatic write_reg(input logic idx, input logic [31:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == sbdfr_pkg::REG_LIST_BASE) begin
			base_reg = val;
			walk_ptr = val;
			walk_count = 0;
		end else begin
			storage_on = val[0];
		end
		reg_writes++;
	endtask

	// Sampled at the falling edge so that the driver's updates have settled.
	task automatic settle();
		while (frame_q.size() != 0 || in_valid || pending_words.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				respond(in_data);
				frames_taken <= frames_taken + 1;
			end
			if (!in_valid || !in_stall) begin
				if (frame_q.size() > 0 && (calm || $urandom_range(99) >= 29)) begin
					in_valid <= 1'b1;
					in_data <= frame_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		sbdfr_pkg::out_word_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				words_seen++;
				if (pending_words.size() == 0) begin
					$error("response word at %h with nothing expected",
						out_data.write_address);
					errors++;
				end else begin
					want = pending_words.pop_front();
					check_field("write_address", want.write_address,
						out_data.write_address);
					check_field("write_word", want.write_word, out_data.write_word);
					check_field("frame_last", 32'(want.frame_last),
						32'(out_data.frame_last));
					check_field("walk_ended", 32'(want.walk_ended),
						32'(out_data.walk_ended));
					check_field("next_frame_address", want.next_frame_address,
						out_data.next_frame_address);
					check_field("forward_to_storage", 32'(want.forward_to_storage),
						32'(out_data.forward_to_storage));
				end
			end
			if (hold_left != 0) begin
				out_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (squeeze_req && !squeezed) begin
				squeezed <= 1'b1;
				hold_left <= HOLD_CYCLES;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(99) < 29);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("serial_bus_dma_frame_responder: mismatch");
			$finish;
		end
	end

	initial begin
		sbdfr_pkg::in_word_t w;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: no storage unit, list at address zero.
		w = mk_frame(sbdfr_pkg::PORT_KBD, sbdfr_pkg::BASE_UNIT, sbdfr_pkg::CMD_INFO, 1'b1);
		frame_q.push_back(w);
		w = mk_frame(sbdfr_pkg::PORT_KBD, sbdfr_pkg::BASE_UNIT, sbdfr_pkg::CMD_COND, 1'b0);
		w.key_report = '1;
		frame_q.push_back(w);
		w = mk_frame(sbdfr_pkg::PORT_KBD, 8'hFF, sbdfr_pkg::CMD_COND, 1'b0);
		w.key_report = '0;
		frame_q.push_back(w);
		frame_q.push_back(mk_frame(sbdfr_pkg::PORT_PTR, sbdfr_pkg::BASE_UNIT,
			sbdfr_pkg::CMD_INFO, 1'b0));
		w = mk_frame(sbdfr_pkg::PORT_PTR, sbdfr_pkg::BASE_UNIT, sbdfr_pkg::CMD_COND, 1'b0);
		w.pointer_buttons = 3'd0;
		w.pointer_dx = -8'sd128;
		w.pointer_dy = 8'sd127;
		w.pointer_dz = 8'sd0;
		frame_q.push_back(w);
		w = mk_frame(sbdfr_pkg::PORT_PTR, sbdfr_pkg::BASE_UNIT, sbdfr_pkg::CMD_COND, 1'b0);
		w.pointer_buttons = 3'd7;
		w.pointer_dx = -8'sd1;
		w.pointer_dy = 8'sd1;
		w.pointer_dz = -8'sd128;
		frame_q.push_back(w);
		frame_q.push_back(mk_frame(sbdfr_pkg::PORT_CTL, sbdfr_pkg::BASE_UNIT,
			sbdfr_pkg::CMD_INFO, 1'b0));
		frame_q.push_back(mk_frame(sbdfr_pkg::PORT_CTL, sbdfr_pkg::BASE_UNIT,
			sbdfr_pkg::CMD_COND, 1'b0));
		frame_q.push_back(mk_frame(sbdfr_pkg::PORT_CTL, 8'h01, sbdfr_pkg::CMD_COND, 1'b0));
		frame_q.push_back(mk_frame(2'd3, sbdfr_pkg::BASE_UNIT, sbdfr_pkg::CMD_INFO, 1'b0));
		frame_q.push_back(mk_frame(sbdfr_pkg::PORT_KBD, sbdfr_pkg::BASE_UNIT, 8'h00, 1'b0));
		w = mk_frame(sbdfr_pkg::PORT_KBD, 8'hDF, sbdfr_pkg::CMD_COND, 1'b1);
		w.frame_header[7:0] = 8'hFF;
		frame_q.push_back(w);
		settle();

		// Storage unit present, list near the top of the address space.
		write_reg(sbdfr_pkg::REG_STORAGE, 32'h0000_0001);
		write_reg(sbdfr_pkg::REG_LIST_BASE, 32'hFFFF_FFF0);
		w = mk_frame(sbdfr_pkg::PORT_CTL, sbdfr_pkg::BASE_UNIT, sbdfr_pkg::CMD_INFO, 1'b0);
		w.receive_address = 32'hFFFF_FFF0;
		w.frame_header[7:0] = 8'hFF;
		frame_q.push_back(w);
		w = mk_frame(sbdfr_pkg::PORT_CTL, 8'hFF, sbdfr_pkg::CMD_COND, 1'b0);
		w.frame_header[7:0] = 8'h00;
		frame_q.push_back(w);
		frame_q.push_back(mk_frame(sbdfr_pkg::PORT_CTL, 8'h01, sbdfr_pkg::CMD_INFO, 1'b0));
		frame_q.push_back(mk_frame(sbdfr_pkg::PORT_CTL, 8'hDF, 8'hFF, 1'b0));
		frame_q.push_back(mk_frame(sbdfr_pkg::PORT_CTL, 8'h00, sbdfr_pkg::CMD_COND, 1'b0));
		w = mk_frame(sbdfr_pkg::PORT_PTR, sbdfr_pkg::BASE_UNIT, sbdfr_pkg::CMD_COND, 1'b1);
		w.receive_address = 32'hFFFF_FFFC;
		w.pointer_dx = 8'sd127;
		w.pointer_dy = -8'sd128;
		w.pointer_dz = 8'sd127;
		frame_q.push_back(w);
		settle();

		// A long list with no end bit runs into the frame limit, with no idling.
		write_reg(sbdfr_pkg::REG_LIST_BASE, $urandom);
		calm = 1'b1;
		repeat (70) frame_q.push_back(rand_frame(1'b0));
		settle();
		calm = 1'b0;

		// Storage write with only the upper bits set leaves the unit absent.
		write_reg(sbdfr_pkg::REG_STORAGE, 32'hFFFF_FFFE);
		write_reg(sbdfr_pkg::REG_LIST_BASE, 32'hFFFF_FFFF);
		squeeze_req = 1'b1;
		repeat (60) frame_q.push_back(rand_frame(1'b1));
		settle();

		write_reg(sbdfr_pkg::REG_STORAGE, 32'h0000_0001);
		write_reg(sbdfr_pkg::REG_LIST_BASE, 32'h0000_0000);
		repeat (70) frame_q.push_back(rand_frame(1'b1));
		settle();
		repeat (32) @(posedge clk);

		$display("Checked %0d response words from %0d frames: %0d info, %0d condition,",
			words_seen, frames_taken, n_info, n_cond);
		$display("%0d no-response, %0d storage notices; walks ended %0d times on %s",
			n_none, n_fwd, end_bit_stops + limit_stops, "the end bit or the frame limit.");
		if (errors == 0)
			$display("serial_bus_dma_frame_responder: match");
		else
			$display("serial_bus_dma_frame_responder: mismatch");
		$finish;
	end

endmodule
